### design/hrlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_pkg: shared types and constants of the request line classifier
// Holds the verdict codes, the result word layout and the character codes
// the parser looks for.
// ----------------------------------------------------------------------------
package hrlc_pkg;

    localparam int HRLC_REQUEST_BYTES = 2048;
    localparam int HRLC_QUEUE_DEPTH   = 4;

    localparam logic [10:0] PATH_LIMIT_RESET = 11'd256;
    localparam logic [10:0] FIELD_MAX        = 11'h7FF;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    typedef enum logic [1:0] {
        VERDICT_OK   = 2'd0,
        VERDICT_405  = 2'd1,
        VERDICT_400  = 2'd2,
        VERDICT_DROP = 2'd3
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [10:0] path_offset;
        logic [10:0] path_length;
        logic [10:0] request_bytes;
    } t_result;

    // Expected method character at a given position of "GET"
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_G;
            2'd1:    ch = CH_E;
            default: ch = CH_T;
        endcase
        return ch;
    endfunction

endpackage

### design/hrlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_front: byte parser of the request line classifier
// Tracks the request line, the header terminator and the byte count, and
// pushes one result word into the queue when a request is decided.
// ----------------------------------------------------------------------------
module hrlc_front import hrlc_pkg::*; #(
    parameter int REQUEST_BYTES = HRLC_REQUEST_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    input  logic [10:0] i_path_limit,
    output logic        o_push,
    output t_result     o_result
);

    localparam int CW = $clog2(REQUEST_BYTES);
    localparam logic [CW-1:0] LAST_COUNT = CW'(REQUEST_BYTES - 1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_METHOD,
        PH_GAP,
        PH_PATH,
        PH_TAIL,
        PH_DONE
    } t_phase;

    t_phase        r_phase,  n_phase;
    logic [2:0]    r_mprog,  n_mprog;
    logic          r_mmis,   n_mmis;
    logic [10:0]   r_pbegin, n_pbegin;
    logic [10:0]   r_pcount, n_pcount;
    logic          r_pdot,   n_pdot;
    logic          r_pbad,   n_pbad;
    logic [CW-1:0] r_total,  n_total;
    logic [1:0]    r_term,   n_term;
    logic          r_saw_lf, n_saw_lf;
    logic          r_wait,   n_wait;

    logic     is_cr, is_lf, is_sp, is_dot;
    logic     do_method;
    t_verdict verdict;

    function automatic t_verdict judge(
        input logic [2:0]  mprog,
        input logic        mmis,
        input logic [10:0] pcount,
        input logic        pbad,
        input logic [10:0] limit
    );
        t_verdict v;
        if (mprog == 3'd0) begin
            v = VERDICT_400;
        end else if (mprog != 3'd3 || mmis) begin
            v = VERDICT_405;
        end else if (pcount == 11'd0) begin
            v = VERDICT_400;
        end else if (pbad || pcount > limit) begin
            v = VERDICT_400;
        end else begin
            v = VERDICT_OK;
        end
        return v;
    endfunction

    function automatic logic [10:0] to_field(input logic [CW-1:0] value);
        logic [CW+10:0] ext;
        ext = {11'd0, value};
        return ext[10:0];
    endfunction

    assign is_cr  = (i_data_byte == CH_CR);
    assign is_lf  = (i_data_byte == CH_LF);
    assign is_sp  = (i_data_byte == CH_SP);
    assign is_dot = (i_data_byte == CH_DOT);

    always_comb begin
        n_phase   = r_phase;
        n_mprog   = r_mprog;
        n_mmis    = r_mmis;
        n_pbegin  = r_pbegin;
        n_pcount  = r_pcount;
        n_pdot    = r_pdot;
        n_pbad    = r_pbad;
        n_total   = r_total;
        n_term    = r_term;
        n_saw_lf  = r_saw_lf;
        n_wait    = r_wait;
        do_method = 1'b0;
        verdict   = VERDICT_DROP;
        o_push    = 1'b0;
        o_result  = '0;

        if (i_accept && i_end_of_stream) begin
            // Close: report unless already reported, then restart the stream
            if (!r_wait) begin
                verdict = r_saw_lf ? judge(r_mprog, r_mmis, r_pcount, r_pbad, i_path_limit)
                                   : VERDICT_DROP;
                o_push = 1'b1;
                o_result.verdict       = verdict;
                o_result.path_offset   = (verdict == VERDICT_DROP) ? 11'd0 : r_pbegin;
                o_result.path_length   = (verdict == VERDICT_OK) ? r_pcount : 11'd0;
                o_result.request_bytes = to_field(r_total);
            end
            n_phase  = PH_LEAD;
            n_mprog  = 3'd0;
            n_mmis   = 1'b0;
            n_pbegin = 11'd0;
            n_pcount = 11'd0;
            n_pdot   = 1'b0;
            n_pbad   = 1'b0;
            n_total  = '0;
            n_term   = 2'd0;
            n_saw_lf = 1'b0;
            n_wait   = 1'b0;
        end else if (i_accept && !r_wait) begin
            if (r_phase != PH_DONE) begin
                if (is_cr || is_lf) begin
                    n_phase = PH_DONE;
                end else begin
                    unique case (r_phase)
                        PH_LEAD: begin
                            if (!is_sp) begin
                                n_phase   = PH_METHOD;
                                do_method = 1'b1;
                            end
                        end
                        PH_METHOD: begin
                            if (is_sp) begin
                                n_phase = PH_GAP;
                            end else begin
                                do_method = 1'b1;
                            end
                        end
                        PH_GAP: begin
                            if (!is_sp) begin
                                n_phase  = PH_PATH;
                                n_pbegin = to_field(r_total);
                                n_pcount = 11'd1;
                                n_pbad   = (i_data_byte != CH_SLASH);
                                n_pdot   = is_dot;
                            end
                        end
                        PH_PATH: begin
                            if (is_sp) begin
                                n_phase = PH_TAIL;
                            end else begin
                                if (r_pcount < FIELD_MAX) begin
                                    n_pcount = r_pcount + 11'd1;
                                end
                                if (r_pdot && is_dot) begin
                                    n_pbad = 1'b1;
                                end
                                n_pdot = is_dot;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (do_method) begin
                if (r_mprog < 3'd3 && i_data_byte != get_char(r_mprog[1:0])) begin
                    n_mmis = 1'b1;
                end
                if (r_mprog < 3'd4) begin
                    n_mprog = r_mprog + 3'd1;
                end
            end

            n_total = r_total + 1'b1;
            if (is_lf) begin
                n_saw_lf = 1'b1;
            end

            // Track CR LF CR LF: odd counts wait for LF
            if (!r_term[0]) begin
                n_term = is_cr ? r_term + 2'd1 : 2'd0;
            end else if (is_lf) begin
                n_term = (r_term == 2'd3) ? 2'd0 : 2'd2;
            end else begin
                n_term = is_cr ? 2'd1 : 2'd0;
            end

            if (r_term == 2'd3 && is_lf) begin
                verdict = judge(n_mprog, n_mmis, n_pcount, n_pbad, i_path_limit);
                o_push  = 1'b1;
                n_wait  = 1'b1;
            end else if (n_total == LAST_COUNT) begin
                verdict = VERDICT_DROP;
                o_push  = 1'b1;
                n_wait  = 1'b1;
            end
            o_result.verdict       = verdict;
            o_result.path_offset   = (verdict == VERDICT_DROP) ? 11'd0 : n_pbegin;
            o_result.path_length   = (verdict == VERDICT_OK) ? n_pcount : 11'd0;
            o_result.request_bytes = to_field(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_mprog  <= 3'd0;
            r_mmis   <= 1'b0;
            r_pbegin <= 11'd0;
            r_pcount <= 11'd0;
            r_pdot   <= 1'b0;
            r_pbad   <= 1'b0;
            r_total  <= '0;
            r_term   <= 2'd0;
            r_saw_lf <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_mprog  <= n_mprog;
            r_mmis   <= n_mmis;
            r_pbegin <= n_pbegin;
            r_pcount <= n_pcount;
            r_pdot   <= n_pdot;
            r_pbad   <= n_pbad;
            r_total  <= n_total;
            r_term   <= n_term;
            r_saw_lf <= n_saw_lf;
            r_wait   <= n_wait;
        end
    end

endmodule

### design/hrlc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_fifo: result queue between parser and output stage
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hrlc_fifo import hrlc_pkg::*; #(
    parameter int DEPTH = HRLC_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT  = NW'(DEPTH);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/hrlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_back: output stage of the request line classifier
// Holds one result word on the output channel and refills from the queue.
// ----------------------------------------------------------------------------
module hrlc_back import hrlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_result i_data,
    output logic    o_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    // Refill when the register is free or its word leaves this cycle
    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

endmodule

### design/http_request_line_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_classifier: HTTP request line checker
// Watches a request byte stream for the header end and classifies the first
// line (GET method, path shape and length) into a one-word verdict.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------
//  in       | sink      | i_in_valid/o_in_stall | i_data_byte, i_end_of_stream
//  out      | source    | o_out_valid/i_out_stall | o_verdict, o_path_offset,
//           |           |                       | o_path_length, o_request_bytes
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | i_cfg_data (path limit)
//
//  One word per cycle is taken on the input while the result queue is not
//  full; the parser updates its state once for each accepted byte.
//  A result passes through the result queue and then the output register.
//  The input stalls only when the result queue (QUEUE_DEPTH words) is full,
//  so a stalled output does not hold the parser until the queue fills.
//  Reset is synchronous, active low; it clears the parser, the queue and the
//  output valid, and sets the path limit to 256. No clearing pass follows.
//  The configuration port is always ready.
//
module http_request_line_classifier import hrlc_pkg::*; #(
    parameter int REQUEST_BYTES = HRLC_REQUEST_BYTES,
    parameter int QUEUE_DEPTH   = HRLC_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    // verdicts
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    output logic [10:0] o_path_offset,
    output logic [10:0] o_path_length,
    output logic [10:0] o_request_bytes,
    // path limit register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    logic [10:0] r_path_limit;

    logic    w_accept;
    logic    w_push;
    t_result w_push_data;
    logic    w_full;
    logic    w_empty;
    t_result w_head;
    logic    w_pop;
    t_result w_out;

    // Config writes go straight into the limit register; never back-pressure them
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_limit <= PATH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_path_limit <= i_cfg_data;
        end
    end

    // Take a word whenever the queue has room for a possible result
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    hrlc_front #(
        .REQUEST_BYTES (REQUEST_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_path_limit    (r_path_limit),
        .o_push          (w_push),
        .o_result        (w_push_data)
    );

    hrlc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    hrlc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_data   (w_head),
        .o_pop    (w_pop),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (w_out)
    );

    // Fan the held result word out onto the field ports
    assign o_verdict       = w_out.verdict;
    assign o_path_offset   = w_out.path_offset;
    assign o_path_length   = w_out.path_length;
    assign o_request_bytes = w_out.request_bytes;

endmodule

### design/hrlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlc_checker: port-level checks of the request line classifier
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module hrlc_checker import hrlc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_verdict,
    input logic [10:0] o_path_offset,
    input logic [10:0] o_path_length,
    input logic        o_cfg_ready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // Leave reset with nothing queued and room on the input
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall && o_cfg_ready)
        else $error("block not clean after reset");

    // A dropped request carries no path information
    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict == VERDICT_DROP |->
            o_path_offset == 11'd0 && o_path_length == 11'd0)
        else $error("dropped verdict with path fields");

    // Path length only rides along with an ok verdict
    a_length_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict != VERDICT_OK |-> o_path_length == 11'd0)
        else $error("path length on a rejected request");

endmodule

bind http_request_line_classifier hrlc_checker u_hrlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_verdict     (o_verdict),
    .o_path_offset (o_path_offset),
    .o_path_length (o_path_length),
    .o_cfg_ready   (o_cfg_ready)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request line classifier check
// Streams HTTP requests, broken request lines and raw noise into the
// classifier with random idling on both sides. Predicts every verdict word
// from the accepted input words and compares it field by field. Steps the
// path limit through its extremes between streams.
// ----------------------------------------------------------------------------
module testbench;
    import hrlc_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_WORDS  = 1460;
    // slack after the last verdict word, to let the pipeline settle
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [2:0] {
        LINE_LEAD,
        LINE_METHOD,
        LINE_GAP,
        LINE_PATH,
        LINE_TAIL,
        LINE_DONE
    } t_line_phase;

    // Predicts the verdict words from the accepted input words and holds
    // them until the block hands them over.
    class verdict_tracker;
        logic [10:0] limit = PATH_LIMIT_RESET;
        t_line_phase phase;
        logic [2:0]  method_seen;
        bit          method_wrong;
        logic [10:0] path_start;
        logic [10:0] path_len;
        bit          last_dot;
        bit          path_broken;
        logic [10:0] bytes_seen;
        logic [1:0]  crlf_state;
        bit          lf_seen;
        bit          closing;
        t_result     verdicts_due[$];
        int          checked;
        int          fails;

        function void clear_stream();
            phase        = LINE_LEAD;
            method_seen  = '0;
            method_wrong = 1'b0;
            path_start   = '0;
            path_len     = '0;
            last_dot     = 1'b0;
            path_broken  = 1'b0;
            bytes_seen   = '0;
            crlf_state   = '0;
            lf_seen      = 1'b0;
            closing      = 1'b0;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Track the first line: leading spaces, method, gap, path, rest.
        function void scan_line(logic [7:0] b);
            if (phase == LINE_DONE) return;
            if (b == CH_CR || b == CH_LF) begin
                phase = LINE_DONE;
                return;
            end
            case (phase)
                LINE_LEAD, LINE_METHOD: begin
                    if (b == CH_SP) begin
                        if (phase == LINE_METHOD) phase = LINE_GAP;
                    end else begin
                        phase = LINE_METHOD;
                        if (method_seen < 3 &&
                            b != (method_seen == 0 ? CH_G : method_seen == 1 ? CH_E : CH_T))
                            method_wrong = 1'b1;
                        if (method_seen < 4) method_seen++;
                    end
                end
                LINE_GAP: begin
                    if (b != CH_SP) begin
                        phase       = LINE_PATH;
                        path_start  = bytes_seen;
                        path_len    = 11'd1;
                        path_broken = (b != CH_SLASH);
                        last_dot    = (b == CH_DOT);
                    end
                end
                LINE_PATH: begin
                    if (b == CH_SP) begin
                        phase = LINE_TAIL;
                    end else begin
                        if (path_len != FIELD_MAX) path_len++;
                        if (last_dot && b == CH_DOT) path_broken = 1'b1;
                        last_dot = (b == CH_DOT);
                    end
                end
                default: ;
            endcase
        endfunction

        function t_verdict classify();
            if (method_seen == 0) return VERDICT_400;
            if (method_seen != 3 || method_wrong) return VERDICT_405;
            if (path_len == 0) return VERDICT_400;
            if (path_broken || path_len > limit) return VERDICT_400;
            return VERDICT_OK;
        endfunction

        function void queue_verdict(t_verdict v);
            t_result r;
            r.verdict       = v;
            r.path_offset   = (v == VERDICT_DROP) ? '0 : path_start;
            r.path_length   = (v == VERDICT_OK) ? path_len : '0;
            r.request_bytes = bytes_seen;
            verdicts_due.push_back(r);
        endfunction

        // Advance the model by one accepted word; return 1 when the block
        // just drops it (data after the verdict, before the close).
        function bit note_word(logic [7:0] b, bit eos);
            if (eos) begin
                if (!closing) queue_verdict(lf_seen ? classify() : VERDICT_DROP);
                clear_stream();
                return 1'b0;
            end
            if (closing) return 1'b1;
            scan_line(b);
            bytes_seen++;
            if (b == CH_LF) lf_seen = 1'b1;
            if (!crlf_state[0]) begin
                crlf_state = (b == CH_CR) ? crlf_state + 2'd1 : 2'd0;
            end else if (b == CH_LF) begin
                if (crlf_state == 2'd3) begin
                    queue_verdict(classify());
                    closing    = 1'b1;
                    crlf_state = 2'd0;
                    return 1'b0;
                end
                crlf_state = 2'd2;
            end else begin
                crlf_state = (b == CH_CR) ? 2'd1 : 2'd0;
            end
            if (bytes_seen == 11'(HRLC_REQUEST_BYTES - 1)) begin
                queue_verdict(VERDICT_DROP);
                closing = 1'b1;
            end
            return 1'b0;
        endfunction

        task report_mismatch(string msg);
            fails++;
            $display("MISMATCH %0d: %s", fails, msg);
        endtask

        task check_verdict(input logic [1:0] verdict, input logic [10:0] offset,
                           input logic [10:0] length, input logic [10:0] nbytes);
            t_result want;
            checked++;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict word %0d arrived with none due", checked));
                return;
            end
            want = verdicts_due.pop_front();
            if (verdict !== want.verdict)
                report_mismatch($sformatf("word %0d verdict %0d, want %0d",
                                          checked, verdict, want.verdict));
            if (offset !== want.path_offset)
                report_mismatch($sformatf("word %0d path_offset %0d, want %0d",
                                          checked, offset, want.path_offset));
            if (length !== want.path_length)
                report_mismatch($sformatf("word %0d path_length %0d, want %0d",
                                          checked, length, want.path_length));
            if (nbytes !== want.request_bytes)
                report_mismatch($sformatf("word %0d request_bytes %0d, want %0d",
                                          checked, nbytes, want.request_bytes));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [1:0]  o_verdict;
    logic [10:0] o_path_offset;
    logic [10:0] o_path_length;
    logic [10:0] o_request_bytes;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data      = '0;

    verdict_tracker tracker;
    logic [7:0]     frame[$];       // bytes of the stream being built
    bit             no_idle      = 1'b0;
    int             holds_asked  = 0;
    int             holds_done   = 0;
    int             words_sent   = 0;
    int             streams      = 0;
    int             limit_writes = 0;
    int             cycle_count  = 0;

    http_request_line_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_verdict       (o_verdict),
        .o_path_offset   (o_path_offset),
        .o_path_length   (o_path_length),
        .o_request_bytes (o_request_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a verdict that never comes ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d verdict words due",
                     cycle_count, tracker.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Verdict side: take a word, then stall for a random count of cycles.
    // A long hold-off, counted here, lets the result queue fill so the
    // block has to stall its input.
    initial begin : verdict_sink
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.check_verdict(o_verdict, o_path_offset, o_path_length,
                                      o_request_bytes);
                wait_left = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                wait_left  = LONG_HOLD;
            end
            if (wait_left > 0) begin
                i_out_stall <= 1'b1;
                wait_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic void add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) frame.push_back(s[k]);
    endfunction

    function automatic void add_crlf();
        frame.push_back(CH_CR);
        frame.push_back(CH_LF);
    endfunction

    function automatic void add_spaces(input int n);
        repeat (n) frame.push_back(CH_SP);
    endfunction

    // Path of len bytes starting with a slash; dots show up often only when
    // asked, so most paths stay clear of the ".." rule.
    function automatic void add_path(input int len, input bit dots);
        logic [7:0] c;
        frame.push_back(CH_SLASH);
        repeat (len - 1) begin
            case ($urandom_range(0, 7))
                0: c = dots ? CH_DOT : CH_SLASH;
                1: c = CH_SLASH;
                2: begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == CH_SP || c == CH_CR || c == CH_LF);
                end
                default: c = 8'($urandom_range(8'h61, 8'h7A));
            endcase
            frame.push_back(c);
        end
    endfunction

    // Offer one word after a random idle gap; hold it until accepted.
    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= e;
        do @(posedge i_clk); while (o_in_stall);
        if (!tracker.note_word(b, e)) words_sent++;
    endtask

    // Send the built stream, then close it; the data byte of the close
    // word is random since the block ignores it.
    task automatic send_frame();
        foreach (frame[k]) send_word(frame[k], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        streams++;
    endtask

    // Drop valid, wait until every verdict is in, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_limit(input logic [10:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.limit = v;
        limit_writes++;
    endtask

    initial begin : request_source
        int          start_words;
        int          plen;
        int          n;
        logic [7:0]  c;
        logic [10:0] next_limit;

        tracker = new();
        tracker.clear_stream();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part, path limit at its reset value ---
        // close on an empty stream: dropped, no bytes counted
        frame.delete();
        send_frame();
        // shortest good request; a byte past the header end is dropped and
        // the close that follows gives no verdict
        frame.delete();
        add_text("GET /");
        add_crlf();
        add_crlf();
        frame.push_back(8'hFF);
        send_frame();
        // bare line feed, then close: empty method
        frame.delete();
        frame.push_back(CH_LF);
        send_frame();
        // first line never ends: no line feed, so dropped at the close
        frame.delete();
        frame.push_back(8'h00);
        frame.push_back(8'h7F);
        send_frame();
        // method with no path
        frame.delete();
        add_text("GET");
        frame.push_back(CH_LF);
        send_frame();

        // --- random part ---
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            // step the path limit now and then, extremes first
            if (streams % 8 == 7) begin
                case (limit_writes)
                    0: next_limit = 11'd1;
                    1: next_limit = 11'd0;
                    2: next_limit = FIELD_MAX;
                    3: next_limit = 11'd2;
                    default: begin
                        case ($urandom_range(0, 3))
                            0, 1:    next_limit = 11'($urandom_range(0, 40));
                            2:       next_limit = 11'($urandom_range(0, 2047));
                            default: next_limit = PATH_LIMIT_RESET;
                        endcase
                    end
                endcase
                load_limit(next_limit);
            end

            // back-pressure burst: hold the output off and keep feeding
            // tiny streams so the result queue fills up
            if (streams % 25 == 5) begin
                holds_asked++;
                no_idle = 1'b1;
                repeat (12) begin
                    frame.delete();
                    if ($urandom_range(0, 1)) begin
                        frame.push_back(CH_LF);
                    end else begin
                        add_text("GET /");
                        add_crlf();
                        add_crlf();
                    end
                    send_frame();
                end
            end

            frame.delete();
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 15) begin
                // raw noise, weighted toward the bytes the parser reacts to
                n = $urandom_range(1, 24);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       frame.push_back(CH_CR);
                        1:       frame.push_back(CH_LF);
                        2:       frame.push_back(CH_SP);
                        3:       frame.push_back(CH_DOT);
                        default: frame.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 3));
                case ($urandom_range(0, 11))
                    0:       ;                  // line ends before any method
                    1:       add_text("GE");
                    2:       add_text("GETS");
                    3:       add_text("get");
                    4:       add_text("POST");
                    5:       frame.push_back(8'($urandom_range(8'h21, 8'hFF)));
                    default: add_text("GET");
                endcase
                // path, left out now and then; lengths hug a small limit
                if ($urandom_range(0, 9) != 0) begin
                    add_spaces($urandom_range(1, 3));
                    if (tracker.limit <= 40 && $urandom_range(0, 1))
                        plen = int'(tracker.limit) + int'($urandom_range(0, 2)) - 1;
                    else
                        plen = $urandom_range(1, 12);
                    if (plen < 1) plen = 1;
                    add_path(plen, $urandom_range(0, 2) == 0);
                    // spoil the leading slash
                    if ($urandom_range(0, 9) == 0)
                        frame[frame.size() - plen] = $urandom_range(0, 1) ? CH_DOT : CH_E;
                    if ($urandom_range(0, 7) != 0) add_text(" HTTP/1.1");
                end
                if ($urandom_range(0, 5) == 0) frame.push_back(CH_LF);
                else add_crlf();
                repeat ($urandom_range(0, 2)) begin
                    add_text("Host:");
                    repeat ($urandom_range(1, 6)) begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                        frame.push_back(c);
                    end
                    add_crlf();
                end
                case ($urandom_range(0, 6))
                    0: ;                        // close right after the last line feed
                    1: begin                    // cut short anywhere
                        n = $urandom_range(0, frame.size() - 1);
                        while (frame.size() > n) frame.delete(frame.size() - 1);
                    end
                    default: begin              // header end plus trailing bytes
                        add_crlf();
                        repeat ($urandom_range(0, 3))
                            frame.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            send_frame();
            // a second close on a fresh stream is dropped with zero bytes
            if ($urandom_range(0, 19) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
        end

        // --- a path past the reset limit, accepted at the widest limit ---
        no_idle = 1'b0;
        load_limit(FIELD_MAX);
        frame.delete();
        add_text("GET ");
        add_path(300, 1'b0);
        add_text(" HTTP/1.1");
        add_crlf();
        add_crlf();
        send_frame();

        drain();
        $display("Run: %0d request words in %0d streams, %0d verdict words checked,",
                 words_sent, streams, tracker.checked);
        $display("     %0d path limit loads from 0 to 2047, %0d long output hold-offs.",
                 limit_writes, holds_done);
        if (tracker.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
